@@ rtl/core/loss_function_accumulator_core_assert.svh @@
// Assertion macros shared by the loss accumulator RTL.
// Needs a clock and an active-low reset name passed in by the user.
`ifndef LOSS_FUNCTION_ACCUMULATOR_CORE_ASSERT_SVH
`define LOSS_FUNCTION_ACCUMULATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define LFA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("loss accumulator assertion failed");

// Next-cycle implication.
`define LFA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("loss accumulator assertion failed");

`endif

@@ rtl/core/lfa_pkg.sv @@
// Shared types and constants for the loss accumulator.
// No dependencies.
`default_nettype none
package lfa_pkg;
  localparam int FRAC_BITS = 16;
  localparam int MUL_W     = 33;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic [1:0] KIND_SE  = 2'd0;
  localparam logic [1:0] KIND_AE  = 2'd1;
  localparam logic [1:0] KIND_BCE = 2'd2;
  localparam logic [1:0] KIND_CE  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_CLAMP = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  typedef struct packed {
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;
endpackage
`default_nettype wire

@@ rtl/core/lfa_mul.sv @@
// Shared unsigned multiplier with registered product.
// Depends on lfa_pkg.
`default_nettype none
module lfa_mul (
  input  wire                              clk,
  input  lfa_pkg::mul_req_t                req,
  output logic [2*lfa_pkg::MUL_W-1:0]      prod_r
);
  import lfa_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= req.a * req.b;
  end
endmodule
`default_nettype wire

@@ rtl/core/loss_function_accumulator_core.sv @@
// Loss accumulator core: per-beat loss, saturating total, mean on end of set.
// The shared 33x33 multiplier sets the log cost (16 squarings per log).
// End of set runs setup, 64 divide steps and saturate, then loads the output register.
// One beat at a time; in_tready is high only while the sequencer is idle.
// rst_n synchronous active low: clears totals, count, flags, loss_kind and output valid.
`default_nettype none
`include "loss_function_accumulator_core_assert.svh"
module loss_function_accumulator_core #(
  parameter int MAX_SAMPLES = 65536
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_wdata,     // loss_kind
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,      // [31:0] target, [63:32] predicted
  input  wire         in_tuser,      // last_in_sample
  input  wire         in_tlast,      // last_in_set
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,     // mean_loss
  output logic [1:0]  out_tuser      // status
);
  import lfa_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

  // sequencer codes
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SQ_MUL   = 4'd1;
  localparam logic [3:0] S_SQ_ACC   = 4'd2;
  localparam logic [3:0] S_LN_INIT  = 4'd3;
  localparam logic [3:0] S_NORM     = 4'd4;
  localparam logic [3:0] S_LOG_MUL  = 4'd5;
  localparam logic [3:0] S_LOG_UPD  = 4'd6;
  localparam logic [3:0] S_LN2_MUL  = 4'd7;
  localparam logic [3:0] S_LN2_UPD  = 4'd8;
  localparam logic [3:0] S_TERM_MUL = 4'd9;
  localparam logic [3:0] S_TERM_UPD = 4'd10;
  localparam logic [3:0] S_ADD      = 4'd11;
  localparam logic [3:0] S_DIV_INIT = 4'd12;
  localparam logic [3:0] S_DIV      = 4'd13;
  localparam logic [3:0] S_RES      = 4'd14;
  localparam logic [3:0] S_OUT      = 4'd15;

  localparam logic signed [32:0] ONE = 33'sd1 <<< FRAC_BITS;

  logic [3:0]              state_r;
  logic [1:0]              kind_r;
  logic signed [31:0]      t_r, p_r;
  logic                    sample_r, set_r, pass_r, neg_r, clamp_r;
  logic [32:0]             x_r;
  logic [5:0]              lz_r, step_r;
  logic [30:0]             m_r;
  logic [FRAC_BITS-1:0]    frac_r;
  logic signed [33:0]      ln_r;
  logic signed [63:0]      elem_r, total_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [63:0]             dq_r;
  logic [CNT_W-1:0]        rem_r;
  logic [31:0]             res_data_r, out_data_r;
  logic [1:0]              res_stat_r, out_stat_r;
  logic                    out_valid_r;

  mul_req_t                mreq;
  logic [2*MUL_W-1:0]      prod_r;

  lfa_mul u_mul (.clk(clk), .req(mreq), .prod_r(prod_r));

  // element difference straight off the bus, for the accept cycle
  logic signed [32:0] diff_w;
  logic [32:0]        ad_w;
  assign diff_w = {in_tdata[31], in_tdata[31:0]} - {in_tdata[63], in_tdata[63:32]};
  assign ad_w   = diff_w[32] ? 33'(-diff_w) : 33'(diff_w);

  // log argument and multiplier operand for the current pass
  logic signed [32:0] arg_w, tm_w;
  logic [32:0]        tm_abs_w, ln_abs_w;
  assign arg_w    = pass_r ? (ONE - 33'(p_r)) : 33'(p_r);
  assign tm_w     = pass_r ? (ONE - 33'(t_r)) : 33'(t_r);
  assign tm_abs_w = tm_w[32] ? 33'(-tm_w) : 33'(tm_w);
  assign ln_abs_w = ln_r[33] ? 33'(-ln_r) : 33'(ln_r);

  // log2 = (16 - lz) * 2^F + frac; lz is leading zeros of the 33-bit argument
  logic signed [6:0]  exp_w;
  logic signed [22:0] lg_w;
  logic [22:0]        lg_abs_w;
  assign exp_w    = 7'sd16 - $signed({1'b0, lz_r});
  assign lg_w     = {exp_w, {FRAC_BITS{1'b0}}} + 23'($unsigned(frac_r));
  assign lg_abs_w = lg_w[22] ? 23'(-lg_w) : 23'(lg_w);

  // normalize step: shift by 32,16,..,1 when top bits are clear
  logic [5:0]  sh_w;
  logic        top_zero_w;
  logic [32:0] x_sh_w;
  assign sh_w       = 6'd32 >> step_r;
  assign top_zero_w = ((x_r >> (7'd33 - {1'b0, sh_w})) == 33'd0);
  assign x_sh_w     = top_zero_w ? (x_r << sh_w) : x_r;

  logic [31:0] sq_w;
  assign sq_w = prod_r[61:30];

  // saturating total update
  logic signed [63:0] sum_w;
  logic               ovf_w;
  assign sum_w = total_r + elem_r;
  assign ovf_w = (total_r[63] == elem_r[63]) && (sum_w[63] != total_r[63]);

  // one restoring-divide step
  logic [CNT_W:0] rem_sh_w;
  logic           ge_w;
  assign rem_sh_w = {rem_r, dq_r[63]};
  assign ge_w     = rem_sh_w >= {1'b0, cnt_r};

  // result moves into the output register once that register is free
  logic out_load_w;
  assign out_load_w = (state_r == S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    mreq.a = '0;
    mreq.b = '0;
    case (state_r)
      S_SQ_MUL: begin
        mreq.a = x_r;
        mreq.b = x_r;
      end
      S_LOG_MUL: begin
        mreq.a = {2'b00, m_r};
        mreq.b = {2'b00, m_r};
      end
      S_LN2_MUL: begin
        mreq.a = {10'd0, lg_abs_w};
        mreq.b = {1'b0, LN2_Q32};
      end
      S_TERM_MUL: begin
        mreq.a = tm_abs_w;
        mreq.b = ln_abs_w;
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load_w) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= KIND_SE;
      total_r     <= '0;
      cnt_r       <= '0;
      clamp_r     <= 1'b0;
    end else begin
      if (cfg_we) kind_r <= cfg_wdata;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            t_r      <= in_tdata[31:0];
            p_r      <= in_tdata[63:32];
            sample_r <= in_tuser;
            set_r    <= in_tlast;
            pass_r   <= 1'b0;
            x_r      <= ad_w;
            // abs error is the difference magnitude itself
            elem_r   <= (kind_r == KIND_AE) ? 64'(ad_w) : 64'd0;
            case (kind_r)
              KIND_SE: state_r <= S_SQ_MUL;
              KIND_AE: state_r <= S_ADD;
              default: state_r <= S_LN_INIT;
            endcase
          end
        end
        S_SQ_MUL: state_r <= S_SQ_ACC;
        S_SQ_ACC: begin
          elem_r  <= 64'(prod_r[2*MUL_W-1:FRAC_BITS]);
          state_r <= S_ADD;
        end
        S_LN_INIT: begin
          // non-positive argument is clamped to one lsb
          if (arg_w[32] || arg_w == 33'sd0) begin
            x_r     <= 33'd1;
            clamp_r <= 1'b1;
          end else begin
            x_r <= arg_w;
          end
          lz_r    <= '0;
          step_r  <= '0;
          state_r <= S_NORM;
        end
        S_NORM: begin
          x_r  <= x_sh_w;
          lz_r <= top_zero_w ? lz_r + sh_w : lz_r;
          if (step_r == 6'd5) begin
            m_r     <= x_sh_w[32:2];
            frac_r  <= '0;
            step_r  <= '0;
            state_r <= S_LOG_MUL;
          end else begin
            step_r <= step_r + 6'd1;
          end
        end
        S_LOG_MUL: state_r <= S_LOG_UPD;
        S_LOG_UPD: begin
          m_r    <= sq_w[31] ? sq_w[31:1] : sq_w[30:0];
          frac_r <= {frac_r[FRAC_BITS-2:0], sq_w[31]};
          step_r <= step_r + 6'd1;
          state_r <= (step_r == 6'(FRAC_BITS - 1)) ? S_LN2_MUL : S_LOG_MUL;
        end
        S_LN2_MUL: begin
          neg_r   <= lg_w[22];
          state_r <= S_LN2_UPD;
        end
        S_LN2_UPD: begin
          ln_r    <= neg_r ? -$signed(prod_r[65:32]) : $signed(prod_r[65:32]);
          state_r <= S_TERM_MUL;
        end
        S_TERM_MUL: begin
          neg_r   <= tm_w[32] ^ ln_r[33];
          state_r <= S_TERM_UPD;
        end
        S_TERM_UPD: begin
          // loss -= t * ln(arg)
          if (neg_r) elem_r <= elem_r + 64'(prod_r[2*MUL_W-1:FRAC_BITS]);
          else       elem_r <= elem_r - 64'(prod_r[2*MUL_W-1:FRAC_BITS]);
          if (kind_r == KIND_BCE && !pass_r) begin
            pass_r  <= 1'b1;
            state_r <= S_LN_INIT;
          end else begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          if (ovf_w) total_r <= total_r[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          else       total_r <= sum_w;
          if (sample_r && cnt_r < CNT_W'(MAX_SAMPLES)) cnt_r <= cnt_r + 1'b1;
          state_r <= set_r ? S_DIV_INIT : S_IDLE;
        end
        S_DIV_INIT: begin
          if (cnt_r == '0) begin
            res_data_r <= '0;
            res_stat_r <= ST_EMPTY;
            state_r    <= S_OUT;
          end else begin
            dq_r    <= total_r[63] ? 64'(-total_r) : 64'(total_r);
            neg_r   <= total_r[63];
            rem_r   <= '0;
            step_r  <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r  <= ge_w ? CNT_W'(rem_sh_w - {1'b0, cnt_r}) : CNT_W'(rem_sh_w);
          dq_r   <= {dq_r[62:0], ge_w};
          step_r <= step_r + 6'd1;
          if (step_r == 6'd63) state_r <= S_RES;
        end
        S_RES: begin
          if (!neg_r && dq_r > 64'h7FFF_FFFF) begin
            res_data_r <= 32'h7FFF_FFFF;
            res_stat_r <= ST_SAT;
          end else if (neg_r && dq_r > 64'h8000_0000) begin
            res_data_r <= 32'h8000_0000;
            res_stat_r <= ST_SAT;
          end else begin
            res_data_r <= neg_r ? -dq_r[31:0] : dq_r[31:0];
            res_stat_r <= clamp_r ? ST_CLAMP : ST_OK;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          // wait for the output register to free up
          if (out_load_w) begin
            out_data_r  <= res_data_r;
            out_stat_r  <= res_stat_r;
            total_r     <= '0;
            cnt_r       <= '0;
            clamp_r     <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `LFA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `LFA_ASSERT_IMP(a_valid_from_out, clk, rst_n, $rose(out_tvalid), $past(state_r) == S_OUT)
  `LFA_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(MAX_SAMPLES))
  `LFA_ASSERT_IMP(a_empty_zero, clk, rst_n, out_tvalid && out_tuser == ST_EMPTY,
                  out_tdata == 32'd0)
endmodule
`default_nettype wire
